// ----- hdl/pcif_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcif_pkg
// Types, codes and helper functions for the press cycle interlock controller.
// ----------------------------------------------------------------------------
package pcif_pkg;

  localparam int unsigned StateW = 4;
  localparam int unsigned DriveW = 2;

  typedef enum logic [StateW-1:0] {
    ST_ENTRY_HOLD        = 4'd0,
    ST_INIT_UP           = 4'd1,
    ST_READY_TOP         = 4'd2,
    ST_PRESS_DOWN        = 4'd3,
    ST_PAUSE_PRESS       = 4'd4,
    ST_RET_SUCCESS       = 4'd5,
    ST_PAUSE_RET_SUCCESS = 4'd6,
    ST_RET_ABORTED       = 4'd7,
    ST_PAUSE_RET_ABORTED = 4'd8,
    ST_SAFE_STOP         = 4'd9
  } press_state_e;

  typedef enum logic [DriveW-1:0] {
    DRV_STOP = 2'd0,
    DRV_UP   = 2'd1,
    DRV_DOWN = 2'd2
  } drive_e;

  // One tick's sensor snapshot.
  typedef struct packed {
    logic start_rise;
    logic overcurrent_edge;
    logic overcurrent_level;
    logic bottom_edge;
    logic bottom_level;
    logic top_edge;
    logic top_level;
    logic door_shut;
    logic fault_reset_req;
    logic estop;
  } sensors_t;

  // Operational entry: open door pauses, else climb until the top endstop.
  function automatic press_state_e entry_state(input logic door, input logic top);
    press_state_e s;
    if (!door) begin
      s = ST_ENTRY_HOLD;
    end else if (!top) begin
      s = ST_INIT_UP;
    end else begin
      s = ST_READY_TOP;
    end
    return s;
  endfunction

  function automatic drive_e drive_of(input press_state_e s);
    drive_e d;
    case (s)
      ST_INIT_UP, ST_RET_SUCCESS, ST_RET_ABORTED: d = DRV_UP;
      ST_PRESS_DOWN:                              d = DRV_DOWN;
      default:                                    d = DRV_STOP;
    endcase
    return d;
  endfunction

endpackage

// ----- hdl/press_cycle_interlock_fsm_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// press_cycle_interlock_fsm_top
// Press cycle interlock state machine with streaming sensor input and
// streaming state/drive output.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Width  Contents
//  s_axis    in         16     one sensor snapshot per transfer
//  m_axis    out        8      new state, drive command, success/abort pulses
//
// A snapshot is captured in the input register; from there the next-state
// logic writes the state register and the result register together, once
// the result register is free or emptying. One transfer per cycle is
// sustained while the output is not stalled; the only loop is the state
// register update.
// Reset puts the machine in the entry hold state with operational re-entry
// pending. A stalled output holds the result register and the input register
// fills behind it; the input side stalls only when both are occupied.
// ----------------------------------------------------------------------------
module press_cycle_interlock_fsm_top
  import pcif_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata bits from bit 0: estop, fault_reset_req, door_shut, top_level,
  // top_edge, bottom_level, bottom_edge, overcurrent_level, overcurrent_edge,
  // start_rise, then six zero bits.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,
  // tdata bits from bit 0: press_state[3:0], drive_cmd[5:4], success_pulse[6],
  // abort_pulse[7].
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o
);

  // Input register stage.
  logic     in_valid_q;
  sensors_t in_q;

  // Machine state.
  press_state_e state_q, state_d;
  logic         reentry_q, reentry_d;

  // Result register stage.
  logic         out_valid_q;
  press_state_e out_state_q;
  drive_e       out_drive_q;
  logic         out_succ_q, out_abrt_q;
  logic         succ_d, abrt_d;

  // The input stage advances when the result register is free or emptying.
  logic advance;
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_q <= s_axis_tdata_i[9:0];
    end
  end

  // Next-state logic for one snapshot.
  always_comb begin
    state_d   = state_q;
    reentry_d = reentry_q;
    succ_d    = 1'b0;
    abrt_d    = 1'b0;
    if (state_q == ST_SAFE_STOP) begin
      // Only a fault reset without emergency stop leaves the safe stop.
      if (in_q.fault_reset_req && !in_q.estop) begin
        state_d   = entry_state(in_q.door_shut, in_q.top_level);
        reentry_d = 1'b0;
      end
    end else if (in_q.estop) begin
      state_d   = ST_SAFE_STOP;
      reentry_d = 1'b1;
    end else if (reentry_q) begin
      state_d   = entry_state(in_q.door_shut, in_q.top_level);
      reentry_d = 1'b0;
    end else begin
      case (state_q)
        ST_ENTRY_HOLD: begin
          if (in_q.door_shut) begin
            state_d = in_q.top_level ? ST_READY_TOP : ST_INIT_UP;
          end
        end
        ST_INIT_UP: begin
          if (!in_q.door_shut) begin
            state_d = ST_ENTRY_HOLD;
          end else if (in_q.top_edge) begin
            state_d = ST_READY_TOP;
          end
        end
        ST_READY_TOP: begin
          if (in_q.door_shut && in_q.start_rise) begin
            state_d = ST_PRESS_DOWN;
          end
        end
        ST_PRESS_DOWN: begin
          // Door first, then completion by endstop or over-current, then abort.
          if (!in_q.door_shut) begin
            state_d = ST_PAUSE_PRESS;
          end else if (in_q.bottom_edge || in_q.overcurrent_edge) begin
            state_d = ST_RET_SUCCESS;
            succ_d  = 1'b1;
          end else if (in_q.start_rise) begin
            state_d = ST_RET_ABORTED;
            abrt_d  = 1'b1;
          end
        end
        ST_PAUSE_PRESS: begin
          // On resume, a level already at the bottom or over-current counts
          // as a completed press.
          if (in_q.door_shut) begin
            if (in_q.bottom_level || in_q.overcurrent_level) begin
              state_d = ST_RET_SUCCESS;
              succ_d  = 1'b1;
            end else begin
              state_d = ST_PRESS_DOWN;
            end
          end
        end
        ST_RET_ABORTED: begin
          if (!in_q.door_shut) begin
            state_d = ST_PAUSE_RET_ABORTED;
          end else if (in_q.top_edge) begin
            state_d = ST_READY_TOP;
          end
        end
        ST_PAUSE_RET_ABORTED: begin
          if (in_q.door_shut) begin
            state_d = in_q.top_level ? ST_READY_TOP : ST_RET_ABORTED;
          end
        end
        ST_RET_SUCCESS: begin
          if (!in_q.door_shut) begin
            state_d = ST_PAUSE_RET_SUCCESS;
          end else if (in_q.top_edge) begin
            state_d = ST_READY_TOP;
          end
        end
        ST_PAUSE_RET_SUCCESS: begin
          if (in_q.door_shut) begin
            state_d = in_q.top_level ? ST_READY_TOP : ST_RET_SUCCESS;
          end
        end
        default: begin
          // Unused codes re-enter through operational entry resolution.
          state_d = entry_state(in_q.door_shut, in_q.top_level);
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ENTRY_HOLD;
      reentry_q   <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        state_q     <= state_d;
        reentry_q   <= reentry_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Every pulse-raising transition changes the state, so the flags pass as is.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_state_q <= state_d;
      out_drive_q <= drive_of(state_d);
      out_succ_q  <= succ_d;
      out_abrt_q  <= abrt_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_abrt_q, out_succ_q, out_drive_q, out_state_q};

endmodule
